// ----- src/rc6_pkg.sv -----
// rc6 engine package: sizes, constants, command and state types, rotate helpers
`default_nettype none

package rc6_pkg;

  localparam int ROUNDS        = 20;
  localparam int MAX_KEY_WORDS = 8;
  localparam int NUM_RK        = 2 * ROUNDS + 4;
  localparam int NUM_PAIRS     = NUM_RK / 2;
  localparam int RK_AW         = $clog2(NUM_RK);
  localparam int PAIR_W        = $clog2(NUM_PAIRS);
  localparam int KB_AW         = (MAX_KEY_WORDS > 1) ? $clog2(MAX_KEY_WORDS) : 1;
  localparam int KC_W          = $clog2(MAX_KEY_WORDS + 1);
  localparam int MIX_MAX       = 3 * ((NUM_RK > MAX_KEY_WORDS) ? NUM_RK : MAX_KEY_WORDS);
  localparam int STEP_W        = $clog2(MIX_MAX + 1);

  localparam logic [31:0] P32 = 32'hB7E15163;
  localparam logic [31:0] Q32 = 32'h9E3779B9;

  typedef enum logic [1:0] {
    CMD_KEY  = 2'd0,
    CMD_ENC  = 2'd1,
    CMD_DEC  = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KINIT,
    ST_KRD,
    ST_KA,
    ST_KB,
    ST_P0,
    ST_P1,
    ST_P2,
    ST_DONE
  } state_t;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] w;
    w = {x, x} << n;
    return w[63:32];
  endfunction

  function automatic logic [31:0] rotr32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] w;
    w = {x, x} >> n;
    return w[31:0];
  endfunction

  function automatic logic [31:0] quad_rot(input logic [31:0] x);
    logic [31:0] p;
    p = x * {x[30:0], 1'b1};
    return rotl32(p, 5'd5);
  endfunction

endpackage

`default_nettype wire

// ----- src/rc6_ram.sv -----
// generic single write, single read ram with registered read data
`default_nettype none

module rc6_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 44,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- src/rc6_block_cipher_engine.sv -----
// rc6-32/20 block cipher engine top level: sequencer, key schedule and round datapath
//
// usage:
//   input channel (in_valid / in_stall) carries a command with key word and block words.
//   cmd 0 loads one key word; the word marked in_last_key starts the key schedule.
//   cmd 1 encrypts and cmd 2 decrypts the block in_a..in_d; cmd 3 is dropped.
//   the result channel (out_valid / out_stall) returns out_a..out_d for cmd 1 and 2 only.
//   a block takes 22 steps (two whitening steps and 20 rounds), each through states P0, P1 and
//   P2 on the shared multiply/rotate unit and the single read port of the round key ram; no
//   new item is taken until the finished block is registered in the output.
//   a key word without the last mark leaves the engine idle; the last one keeps it busy
//   through table setup of 44 entries, then 132 mixing steps through states KRD, KA and KB.
//   in_stall is high whenever the engine is busy.
//   the output register holds a finished result until its transfer, so a new item can be
//   taken meanwhile; a finished block waits if the previous result is still stalled.
//   reset returns to idle, empties the output and key count, and round keys read as zero
//   until the first key schedule.

`default_nettype none

module rc6_block_cipher_engine
  import rc6_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [31:0] in_key_word,
  input  wire logic        in_last_key,
  input  wire logic [31:0] in_a,
  input  wire logic [31:0] in_b,
  input  wire logic [31:0] in_c,
  input  wire logic [31:0] in_d,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [31:0] out_a,
  output logic      [31:0] out_b,
  output logic      [31:0] out_c,
  output logic      [31:0] out_d
);

  localparam logic [PAIR_W-1:0] LAST_PAIR = PAIR_W'(NUM_PAIRS - 1);
  localparam logic [RK_AW-1:0]  LAST_RK   = RK_AW'(NUM_RK - 1);

  state_t             state_r, state_nxt;
  logic [31:0]        a_r, a_nxt, b_r, b_nxt, c_r, c_nxt, d_r, d_nxt;
  logic [31:0]        t_r, t_nxt, u_r, u_nxt, k0_r, k0_nxt;
  logic [PAIR_W-1:0]  p_r, p_nxt;
  logic               dec_r, dec_nxt;
  logic [RK_AW-1:0]   i_r, i_nxt;
  logic [KB_AW-1:0]   j_r, j_nxt;
  logic [KC_W-1:0]    n_r, n_nxt;
  logic [KC_W-1:0]    kc_r, kc_nxt;
  logic [STEP_W-1:0]  lim_r, lim_nxt, cnt_r, cnt_nxt;
  logic               rk_loaded_r, rk_loaded_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [31:0]        oa_r, oa_nxt, ob_r, ob_nxt, oc_r, oc_nxt, od_r, od_nxt;

  logic               kb_we;
  logic [KB_AW-1:0]   kb_waddr;
  logic [31:0]        kb_wdata, kb_rdata;

  logic               rk_we;
  logic [RK_AW-1:0]   rk_waddr, rk_raddr;
  logic [31:0]        rk_wdata, rk_rdata, rk_q;

  logic               in_xfer;
  logic [31:0]        mul_in, quad_q;
  logic [31:0]        ka_new, kb_new, ab_sum;
  logic [31:0]        ea, ec, da, dc;
  logic [KC_W-1:0]    kc_new, j_inc;
  logic [STEP_W-1:0]  nmax;

  rc6_ram #(.WIDTH(32), .DEPTH(NUM_RK)) u_rk_ram (
    .clk   (clk),
    .we    (rk_we),
    .waddr (rk_waddr),
    .wdata (rk_wdata),
    .raddr (rk_raddr),
    .rdata (rk_rdata)
  );

  // key word buffer, read address follows j and is steady through each mixing step
  rc6_ram #(.WIDTH(32), .DEPTH(MAX_KEY_WORDS)) u_kb_ram (
    .clk   (clk),
    .we    (kb_we),
    .waddr (kb_waddr),
    .wdata (kb_wdata),
    .raddr (j_r),
    .rdata (kb_rdata)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_a     = oa_r;
  assign out_b     = ob_r;
  assign out_c     = oc_r;
  assign out_d     = od_r;

  // round keys read as zero before the first schedule
  assign rk_q = rk_loaded_r ? rk_rdata : 32'd0;

  // shared multiply and rotate unit
  assign mul_in = (state_r == ST_P1) ? d_r : b_r;
  assign quad_q = quad_rot(mul_in);

  // key schedule arithmetic
  assign ka_new = rotl32(rk_q + a_r + b_r, 5'd3);
  assign ab_sum = a_r + b_r;
  assign kb_new = rotl32(kb_rdata + ab_sum, ab_sum[4:0]);
  assign j_inc  = KC_W'(j_r) + KC_W'(1);

  // round arithmetic, k1 comes straight from the ram
  assign ea = rotl32(a_r ^ t_r, u_r[4:0]) + k0_r;
  assign ec = rotl32(c_r ^ u_r, t_r[4:0]) + rk_q;
  assign da = rotr32(a_r - k0_r, u_r[4:0]) ^ t_r;
  assign dc = rotr32(c_r - rk_q, t_r[4:0]) ^ u_r;

  assign kc_new = (kc_r < KC_W'(MAX_KEY_WORDS)) ? kc_r + KC_W'(1) : kc_r;
  assign nmax   = (STEP_W'(kc_new) > STEP_W'(NUM_RK)) ? STEP_W'(kc_new) : STEP_W'(NUM_RK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      kc_r        <= '0;
      rk_loaded_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kc_r        <= kc_nxt;
      rk_loaded_r <= rk_loaded_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    c_r   <= c_nxt;
    d_r   <= d_nxt;
    t_r   <= t_nxt;
    u_r   <= u_nxt;
    k0_r  <= k0_nxt;
    p_r   <= p_nxt;
    dec_r <= dec_nxt;
    i_r   <= i_nxt;
    j_r   <= j_nxt;
    n_r   <= n_nxt;
    lim_r <= lim_nxt;
    cnt_r <= cnt_nxt;
    oa_r  <= oa_nxt;
    ob_r  <= ob_nxt;
    oc_r  <= oc_nxt;
    od_r  <= od_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    c_nxt         = c_r;
    d_nxt         = d_r;
    t_nxt         = t_r;
    u_nxt         = u_r;
    k0_nxt        = k0_r;
    p_nxt         = p_r;
    dec_nxt       = dec_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    n_nxt         = n_r;
    lim_nxt       = lim_r;
    cnt_nxt       = cnt_r;
    kc_nxt        = kc_r;
    rk_loaded_nxt = rk_loaded_r;
    out_valid_nxt = out_valid_r && out_stall;
    oa_nxt        = oa_r;
    ob_nxt        = ob_r;
    oc_nxt        = oc_r;
    od_nxt        = od_r;
    kb_we         = 1'b0;
    kb_waddr      = kc_r[KB_AW-1:0];
    kb_wdata      = in_key_word;
    rk_we         = 1'b0;
    rk_waddr      = i_r;
    rk_wdata      = c_r;
    rk_raddr      = i_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          unique case (cmd_t'(in_cmd)) inside
            CMD_KEY: begin
              kb_we  = (kc_r < KC_W'(MAX_KEY_WORDS));
              kc_nxt = kc_new;
              if (in_last_key) begin
                kc_nxt        = '0;
                n_nxt         = kc_new;
                lim_nxt       = nmax + nmax + nmax;
                i_nxt         = '0;
                c_nxt         = P32;
                rk_loaded_nxt = 1'b1;
                state_nxt     = ST_KINIT;
              end
            end
            CMD_ENC, CMD_DEC: begin
              a_nxt     = in_a;
              b_nxt     = in_b;
              c_nxt     = in_c;
              d_nxt     = in_d;
              dec_nxt   = (cmd_t'(in_cmd) == CMD_DEC);
              p_nxt     = (cmd_t'(in_cmd) == CMD_DEC) ? LAST_PAIR : '0;
              state_nxt = ST_P0;
            end
            default: begin
            end
          endcase
        end
      end

      // table setup: S[v] = P32 + v * Q32
      ST_KINIT: begin
        rk_we = 1'b1;
        c_nxt = c_r + Q32;
        if (i_r == LAST_RK) begin
          i_nxt     = '0;
          j_nxt     = '0;
          a_nxt     = '0;
          b_nxt     = '0;
          cnt_nxt   = '0;
          state_nxt = ST_KRD;
        end else begin
          i_nxt = i_r + RK_AW'(1);
        end
      end

      ST_KRD: begin
        state_nxt = ST_KA;
      end

      ST_KA: begin
        rk_we     = 1'b1;
        rk_wdata  = ka_new;
        a_nxt     = ka_new;
        state_nxt = ST_KB;
      end

      ST_KB: begin
        kb_we    = 1'b1;
        kb_waddr = j_r;
        kb_wdata = kb_new;
        b_nxt    = kb_new;
        i_nxt    = (i_r == LAST_RK) ? '0 : i_r + RK_AW'(1);
        j_nxt    = (j_inc == n_r) ? '0 : j_r + KB_AW'(1);
        cnt_nxt  = cnt_r + STEP_W'(1);
        if (cnt_r == lim_r - STEP_W'(1)) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_KRD;
        end
      end

      ST_P0: begin
        rk_raddr  = {p_r, 1'b0};
        t_nxt     = quad_q;
        state_nxt = ST_P1;
      end

      ST_P1: begin
        rk_raddr  = {p_r, 1'b1};
        k0_nxt    = rk_q;
        u_nxt     = quad_q;
        state_nxt = ST_P2;
      end

      ST_P2: begin
        state_nxt = ST_P0;
        if (!dec_r) begin
          p_nxt = p_r + PAIR_W'(1);
          if (p_r == '0) begin
            b_nxt = b_r + k0_r;
            d_nxt = d_r + rk_q;
          end else if (p_r == LAST_PAIR) begin
            a_nxt     = a_r + k0_r;
            c_nxt     = c_r + rk_q;
            state_nxt = ST_DONE;
          end else begin
            a_nxt = b_r;
            b_nxt = ec;
            c_nxt = d_r;
            d_nxt = ea;
          end
        end else begin
          p_nxt = p_r - PAIR_W'(1);
          if (p_r == LAST_PAIR) begin
            // whitening, then rotate words for the first round
            a_nxt = d_r;
            b_nxt = a_r - k0_r;
            c_nxt = b_r;
            d_nxt = c_r - rk_q;
          end else if (p_r == '0) begin
            b_nxt     = b_r - k0_r;
            d_nxt     = d_r - rk_q;
            state_nxt = ST_DONE;
          end else if (p_r == PAIR_W'(1)) begin
            a_nxt = da;
            c_nxt = dc;
          end else begin
            a_nxt = d_r;
            b_nxt = da;
            c_nxt = b_r;
            d_nxt = dc;
          end
        end
      end

      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          oa_nxt        = a_r;
          ob_nxt        = b_r;
          oc_nxt        = c_r;
          od_nxt        = d_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire
